### hdl/sccdc_pkg.sv
// Shared types and constants for the SCC condensation degree counter.
`default_nettype none

package sccdc_pkg;

  localparam int FIELD_W       = 11;
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 8192;

  typedef struct packed {
    logic [FIELD_W-1:0] source_node;
    logic [FIELD_W-1:0] target_node;
    logic               edge_present;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sources_needed;
    logic [FIELD_W-1:0] edges_to_add;
    logic [FIELD_W-1:0] component_total;
    logic               edge_overflow;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/scc_condensation_degree_counter_core.sv
// An edge item is accepted, then its list heads are read and its list entries written; a last
// item then runs the two depth-first passes and the cross-edge scan.
// The result is held in an output register; a clearing pass over the node tables
// follows each result and also runs after reset, during which no item is accepted.
// Reset is asynchronous, active low; node_count resets to 1.
`default_nettype none

module scc_condensation_degree_counter_core
  import sccdc_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire in_item_t           in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      out_item_t          out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [FIELD_W-1:0] cfg_data_i
);

  localparam int NW   = $clog2(MAX_NODES + 1);
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam int SW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int STKW = NW + EW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_START,
    S_P1_SCAN, S_P1_CHK, S_P1_E, S_P1_POP, S_P1_T, S_P1_V,
    S_P2_START, S_P2_RD, S_P2_F, S_P2_C, S_P2_E, S_P2_POP, S_P2_T, S_P2_V,
    S_X_START, S_X_RD, S_X_AB, S_X_C, S_X_H, S_DONE
  } state_e;

  state_e state_q;

  logic [FIELD_W-1:0] node_count_q;
  logic [NW-1:0]      n_q, s_q, t_q, v_q, scan_q, fin_q, k_q, sp_q, groups_q;
  logic [NW-1:0]      clr_q, with_in_q, with_out_q, ca_q, cb_q;
  logic [NW-1:0]      top_node_q;
  logic [EW-1:0]      top_iter_q, cnt_q, ex_q;
  logic               last_q, ovf_q, out_valid_q;
  out_item_t          out_q;

  // memory ports
  logic [NW-1:0]   fh_ra, fh_wa, rh_ra, rh_wa, vis_ra, vis_wa;
  logic [EW-1:0]   fh_wd, rh_wd, fh_rd_q, rh_rd_q;
  logic            fh_we, rh_we, vis_we, vis_wd, vis_rd_q;
  logic [EW-1:0]   fe_ra, fe_wa, re_ra, re_wa;
  logic            fe_we, re_we;
  logic [EW-1:0]   fn_wd, rn_wd, fn_rd_q, rn_rd_q;
  logic [NW-1:0]   ft_wd, rt_wd, ft_rd_q, rt_rd_q;
  logic [SW-1:0]   fo_ra, fo_wa, stk_ra, stk_wa;
  logic            fo_we, stk_we;
  logic [NW-1:0]   fo_wd, fo_rd_q;
  logic [STKW-1:0] stk_wd, stk_rd_q;
  logic [NW-1:0]   cm_raa, cm_rab, cm_wa, cm_wd, cm_rda_q, cm_rdb_q;
  logic            cm_we;
  logic [NW-1:0]   hi_ra, hi_wa, ho_ra, ho_wa;
  logic            hi_we, ho_we, hi_rd_q, ho_rd_q;

  logic [EW-1:0]   fwd_head [MAX_NODES+1];
  logic [EW-1:0]   rev_head [MAX_NODES+1];
  logic            visited  [MAX_NODES+1];
  logic [NW-1:0]   comp     [MAX_NODES+1];
  logic            has_in   [MAX_NODES+1];
  logic            has_out  [MAX_NODES+1];
  logic [EW-1:0]   fwd_next [MAX_EDGES+1];
  logic [NW-1:0]   fwd_tgt  [MAX_EDGES+1];
  logic [EW-1:0]   rev_next [MAX_EDGES+1];
  logic [NW-1:0]   rev_tgt  [MAX_EDGES+1];
  logic [NW-1:0]   finish   [MAX_NODES];
  logic [STKW-1:0] stk      [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (fh_we) fwd_head[fh_wa] <= fh_wd;
    fh_rd_q <= fwd_head[fh_ra];
  end
  always_ff @(posedge clk_i) begin
    if (rh_we) rev_head[rh_wa] <= rh_wd;
    rh_rd_q <= rev_head[rh_ra];
  end
  always_ff @(posedge clk_i) begin
    if (vis_we) visited[vis_wa] <= vis_wd;
    vis_rd_q <= visited[vis_ra];
  end
  always_ff @(posedge clk_i) begin
    if (cm_we) comp[cm_wa] <= cm_wd;
    cm_rda_q <= comp[cm_raa];
    cm_rdb_q <= comp[cm_rab];
  end
  always_ff @(posedge clk_i) begin
    if (hi_we) has_in[hi_wa] <= ~(state_q == S_CLEAR);
    hi_rd_q <= has_in[hi_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ho_we) has_out[ho_wa] <= ~(state_q == S_CLEAR);
    ho_rd_q <= has_out[ho_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fe_we) begin
      fwd_next[fe_wa] <= fn_wd;
      fwd_tgt[fe_wa]  <= ft_wd;
    end
    fn_rd_q <= fwd_next[fe_ra];
    ft_rd_q <= fwd_tgt[fe_ra];
  end
  always_ff @(posedge clk_i) begin
    if (re_we) begin
      rev_next[re_wa] <= rn_wd;
      rev_tgt[re_wa]  <= rt_wd;
    end
    rn_rd_q <= rev_next[re_ra];
    rt_rd_q <= rev_tgt[re_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fo_we) finish[fo_wa] <= fo_wd;
    fo_rd_q <= finish[fo_ra];
  end
  always_ff @(posedge clk_i) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    stk_rd_q <= stk[stk_ra];
  end

  logic          in_acc, in_ok, full, fwd_ok, rev_ok, x_ok, fin_room;
  logic [EW-1:0] e_new;
  logic [NW-1:0] sp_m1, sp_m2, no_in, no_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ok      = in_data_i.edge_present
                   && (in_data_i.source_node != '0) && (32'(in_data_i.source_node) <= MAX_NODES)
                   && (in_data_i.target_node != '0) && (32'(in_data_i.target_node) <= MAX_NODES);
  assign full       = (32'(cnt_q) >= MAX_EDGES);
  assign e_new      = cnt_q + EW'(1);
  assign sp_m1      = sp_q - NW'(1);
  assign sp_m2      = sp_q - NW'(2);
  assign fin_room   = (32'(fin_q) < MAX_NODES);
  assign fwd_ok     = (ft_rd_q != '0) && (ft_rd_q <= n_q) && (32'(sp_q) < MAX_NODES);
  assign rev_ok     = (rt_rd_q != '0) && (rt_rd_q <= n_q) && (32'(sp_q) < MAX_NODES);
  assign x_ok       = (rt_rd_q != '0) && (rt_rd_q <= n_q) && (ft_rd_q != '0) && (ft_rd_q <= n_q);
  assign no_in      = groups_q - with_in_q;
  assign no_out     = groups_q - with_out_q;

  always_comb begin
    fh_ra = '0; fh_wa = '0; fh_wd = '0; fh_we = 1'b0;
    rh_ra = '0; rh_wa = '0; rh_wd = '0; rh_we = 1'b0;
    vis_ra = '0; vis_wa = '0; vis_wd = 1'b0; vis_we = 1'b0;
    fe_ra = '0; fe_wa = '0; fe_we = 1'b0; fn_wd = '0; ft_wd = '0;
    re_ra = '0; re_wa = '0; re_we = 1'b0; rn_wd = '0; rt_wd = '0;
    fo_ra = '0; fo_wa = '0; fo_wd = '0; fo_we = 1'b0;
    stk_ra = '0; stk_wa = '0; stk_wd = '0; stk_we = 1'b0;
    cm_raa = '0; cm_rab = '0; cm_wa = '0; cm_wd = '0; cm_we = 1'b0;
    hi_ra = '0; hi_wa = '0; hi_we = 1'b0;
    ho_ra = '0; ho_wa = '0; ho_we = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        fh_we = 1'b1; fh_wa = clr_q;
        rh_we = 1'b1; rh_wa = clr_q;
        vis_we = 1'b1; vis_wa = clr_q;
        cm_we = 1'b1; cm_wa = clr_q;
        hi_we = 1'b1; hi_wa = clr_q;
        ho_we = 1'b1; ho_wa = clr_q;
      end
      S_LD_RD: begin
        fh_ra = s_q;
        rh_ra = t_q;
      end
      S_LD_WR: begin
        fe_we = 1'b1; fe_wa = e_new; fn_wd = fh_rd_q; ft_wd = t_q;
        re_we = 1'b1; re_wa = e_new; rn_wd = rh_rd_q; rt_wd = s_q;
        fh_we = 1'b1; fh_wa = s_q; fh_wd = e_new;
        rh_we = 1'b1; rh_wa = t_q; rh_wd = e_new;
      end
      S_P1_SCAN: begin
        vis_ra = scan_q;
        fh_ra  = scan_q;
      end
      S_P1_CHK: begin
        vis_we = !vis_rd_q; vis_wa = scan_q; vis_wd = 1'b1;
      end
      S_P1_E: begin
        if (top_iter_q != '0) begin
          fe_ra = top_iter_q;
        end else begin
          fo_we = fin_room; fo_wa = fin_q[SW-1:0]; fo_wd = top_node_q;
          stk_ra = sp_m2[SW-1:0];
        end
      end
      S_P1_T: begin
        vis_ra = ft_rd_q;
        fh_ra  = ft_rd_q;
      end
      S_P1_V: begin
        vis_we = !vis_rd_q; vis_wa = t_q; vis_wd = 1'b1;
        stk_we = !vis_rd_q; stk_wa = sp_m1[SW-1:0]; stk_wd = {top_node_q, top_iter_q};
      end
      S_P2_RD: fo_ra = SW'(k_q - NW'(1));
      S_P2_F: begin
        cm_raa = fo_rd_q;
        rh_ra  = fo_rd_q;
      end
      S_P2_C: begin
        cm_we = (cm_rda_q == '0); cm_wa = v_q; cm_wd = groups_q + NW'(1);
      end
      S_P2_E: begin
        if (top_iter_q != '0) re_ra = top_iter_q;
        else stk_ra = sp_m2[SW-1:0];
      end
      S_P2_T: begin
        cm_raa = rt_rd_q;
        rh_ra  = rt_rd_q;
      end
      S_P2_V: begin
        cm_we = (cm_rda_q == '0); cm_wa = t_q; cm_wd = groups_q;
        stk_we = (cm_rda_q == '0); stk_wa = sp_m1[SW-1:0];
        stk_wd = {top_node_q, top_iter_q};
      end
      S_X_RD: begin
        re_ra = ex_q;
        fe_ra = ex_q;
      end
      S_X_AB: begin
        cm_raa = rt_rd_q;
        cm_rab = ft_rd_q;
      end
      S_X_C: begin
        hi_ra = cm_rdb_q;
        ho_ra = cm_rda_q;
      end
      S_X_H: begin
        hi_we = !hi_rd_q; hi_wa = cb_q;
        ho_we = !ho_rd_q; ho_wa = ca_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      node_count_q <= FIELD_W'(1);
      clr_q        <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      sp_q         <= '0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_data_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (32'(clr_q) == MAX_NODES) begin
            state_q <= S_IDLE;
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
          end else begin
            clr_q <= clr_q + NW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            s_q    <= NW'(in_data_i.source_node);
            t_q    <= NW'(in_data_i.target_node);
            last_q <= in_data_i.last_item;
            if (node_count_q == '0) n_q <= NW'(1);
            else if (32'(node_count_q) > MAX_NODES) n_q <= NW'(MAX_NODES);
            else n_q <= NW'(node_count_q);
            if (in_ok && full) ovf_q <= 1'b1;
            if (in_ok && !full) state_q <= S_LD_RD;
            else if (in_data_i.last_item) state_q <= S_START;
          end
        end
        S_LD_RD: state_q <= S_LD_WR;
        S_LD_WR: begin
          cnt_q   <= e_new;
          state_q <= last_q ? S_START : S_IDLE;
        end
        S_START: begin
          scan_q   <= NW'(1);
          fin_q    <= '0;
          groups_q <= '0;
          state_q  <= S_P1_SCAN;
        end
        S_P1_SCAN: state_q <= S_P1_CHK;
        S_P1_CHK: begin
          if (vis_rd_q) begin
            if (scan_q == n_q) state_q <= S_P2_START;
            else begin
              scan_q  <= scan_q + NW'(1);
              state_q <= S_P1_SCAN;
            end
          end else begin
            top_node_q <= scan_q;
            top_iter_q <= fh_rd_q;
            sp_q       <= NW'(1);
            state_q    <= S_P1_E;
          end
        end
        S_P1_E: begin
          if (top_iter_q != '0) state_q <= S_P1_T;
          else begin
            if (fin_room) fin_q <= fin_q + NW'(1);
            sp_q <= sp_m1;
            if (sp_q == NW'(1)) begin
              if (scan_q == n_q) state_q <= S_P2_START;
              else begin
                scan_q  <= scan_q + NW'(1);
                state_q <= S_P1_SCAN;
              end
            end else state_q <= S_P1_POP;
          end
        end
        S_P1_POP, S_P2_POP: begin
          {top_node_q, top_iter_q} <= stk_rd_q;
          state_q <= (state_q == S_P1_POP) ? S_P1_E : S_P2_E;
        end
        S_P1_T: begin
          top_iter_q <= fn_rd_q;
          t_q        <= ft_rd_q;
          state_q    <= fwd_ok ? S_P1_V : S_P1_E;
        end
        S_P1_V: begin
          if (!vis_rd_q) begin
            top_node_q <= t_q;
            top_iter_q <= fh_rd_q;
            sp_q       <= sp_q + NW'(1);
          end
          state_q <= S_P1_E;
        end
        S_P2_START: begin
          k_q     <= fin_q;
          state_q <= (fin_q == '0) ? S_X_START : S_P2_RD;
        end
        S_P2_RD: state_q <= S_P2_F;
        S_P2_F: begin
          v_q <= fo_rd_q;
          if (fo_rd_q != '0 && 32'(fo_rd_q) <= MAX_NODES) state_q <= S_P2_C;
          else if (k_q == NW'(1)) state_q <= S_X_START;
          else begin
            k_q     <= k_q - NW'(1);
            state_q <= S_P2_RD;
          end
        end
        S_P2_C: begin
          if (cm_rda_q == '0) begin
            groups_q   <= groups_q + NW'(1);
            top_node_q <= v_q;
            top_iter_q <= rh_rd_q;
            sp_q       <= NW'(1);
            state_q    <= S_P2_E;
          end else if (k_q == NW'(1)) state_q <= S_X_START;
          else begin
            k_q     <= k_q - NW'(1);
            state_q <= S_P2_RD;
          end
        end
        S_P2_E: begin
          if (top_iter_q != '0) state_q <= S_P2_T;
          else begin
            sp_q <= sp_m1;
            if (sp_q != NW'(1)) state_q <= S_P2_POP;
            else if (k_q == NW'(1)) state_q <= S_X_START;
            else begin
              k_q     <= k_q - NW'(1);
              state_q <= S_P2_RD;
            end
          end
        end
        S_P2_T: begin
          top_iter_q <= rn_rd_q;
          t_q        <= rt_rd_q;
          state_q    <= rev_ok ? S_P2_V : S_P2_E;
        end
        S_P2_V: begin
          if (cm_rda_q == '0) begin
            top_node_q <= t_q;
            top_iter_q <= rh_rd_q;
            sp_q       <= sp_q + NW'(1);
          end
          state_q <= S_P2_E;
        end
        S_X_START: begin
          ex_q       <= EW'(1);
          with_in_q  <= '0;
          with_out_q <= '0;
          state_q    <= (cnt_q == '0) ? S_DONE : S_X_RD;
        end
        S_X_RD: state_q <= S_X_AB;
        S_X_AB: begin
          if (x_ok) state_q <= S_X_C;
          else if (ex_q == cnt_q) state_q <= S_DONE;
          else begin
            ex_q    <= ex_q + EW'(1);
            state_q <= S_X_RD;
          end
        end
        S_X_C: begin
          ca_q <= cm_rda_q;
          cb_q <= cm_rdb_q;
          if (cm_rda_q != cm_rdb_q) state_q <= S_X_H;
          else if (ex_q == cnt_q) state_q <= S_DONE;
          else begin
            ex_q    <= ex_q + EW'(1);
            state_q <= S_X_RD;
          end
        end
        S_X_H: begin
          if (!hi_rd_q) with_in_q  <= with_in_q + NW'(1);
          if (!ho_rd_q) with_out_q <= with_out_q + NW'(1);
          if (ex_q == cnt_q) state_q <= S_DONE;
          else begin
            ex_q    <= ex_q + EW'(1);
            state_q <= S_X_RD;
          end
        end
        S_DONE: begin
          // wait for the previous result to drain
          if (!out_valid_q || out_ready_i) begin
            out_q.sources_needed  <= FIELD_W'(no_in);
            out_q.edges_to_add    <= FIELD_W'((no_in > no_out) ? no_in : no_out);
            out_q.component_total <= FIELD_W'(groups_q);
            out_q.edge_overflow   <= ovf_q;
            out_valid_q           <= 1'b1;
            clr_q                 <= '0;
            state_q               <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hdl/sccdc_checker.sv
// Port-level checks for the SCC condensation degree counter, bound to the top level.
`default_nettype none

module sccdc_checker
  import sccdc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire in_item_t           in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire out_item_t          out_data_o,
  input wire logic               cfg_we_i,
  input wire logic [FIELD_W-1:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_comp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.component_total != '0)
    else $error("result item with no components");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.edges_to_add >= out_data_o.sources_needed
                 && out_data_o.sources_needed <= out_data_o.component_total)
    else $error("inconsistent counts in result item");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_item |=> !in_ready_o)
    else $error("ready right after a last item");

endmodule

bind scc_condensation_degree_counter_core sccdc_checker u_sccdc_checker (.*);

`default_nettype wire
